/* design/grc_pkg.sv */
package grc_pkg;

    localparam int MAP_CELLS_MAX_DEF = 1024;
    localparam int SCREEN_W = 320;
    localparam int SCREEN_H = 240;
    localparam int TEX_SIZE = 64;
    localparam int HALF_H = SCREEN_H / 2;

    // shared divider: dividend and divisor widths
    localparam int DVD_W = 33;
    localparam int DSR_W = 41;
    // cell distances (sideDist) and per-cell deltas
    localparam int DIST_W = 41;
    localparam int DXY_W = 34;
    // line height width
    localparam int LH_W = $clog2(SCREEN_H * 65536 + 1);

    localparam logic [DXY_W-1:0] DIST_INF = DXY_W'(64'h2_0000_0000);
    localparam logic [21:0] SAT22 = 22'h3F_FFFF;
    localparam logic [23:0] SAT24 = 24'hFF_FFFF;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST = 1'b1;

    typedef enum logic [2:0] {
        CFG_POS_X = 3'd0,
        CFG_POS_Y = 3'd1,
        CFG_DIR_X = 3'd2,
        CFG_DIR_Y = 3'd3,
        CFG_PLANE_X = 3'd4,
        CFG_PLANE_Y = 3'd5,
        CFG_MAP_SIDE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic action;
        logic [9:0] cell_index;
        logic [3:0] cell_value;
        logic [8:0] column;
    } t_in_item;

    typedef struct packed {
        logic [8:0] column_out;
        logic [3:0] texture_id;
        logic hit_side;
        logic [23:0] perp_dist;
        logic [7:0] wall_bottom;
        logic [7:0] wall_top;
        logic [5:0] tex_x;
        logic [21:0] tex_start;
        logic [21:0] tex_step;
        logic out_of_bounds;
    } t_out_item;

    typedef struct packed {
        logic [20:0] pos_x;
        logic [20:0] pos_y;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_y;
        logic signed [17:0] plane_x;
        logic signed [17:0] plane_y;
        logic [5:0] map_side;
    } t_cfg;

    // queued work between front and back
    typedef struct packed {
        logic is_cast;
        logic [9:0] idx;
        logic [3:0] val;
        logic [8:0] col;
    } t_task;

endpackage

/* design/grc_ram.sv */
module grc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input logic i_clk,
    input logic i_we,
    input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input logic [WIDTH-1:0] i_wdata,
    input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/grc_div.sv */
module grc_div (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic [grc_pkg::DVD_W-1:0] i_dividend,
    input logic [grc_pkg::DSR_W-1:0] i_divisor,
    output logic o_done,
    output logic [grc_pkg::DVD_W-1:0] o_quot
);
    import grc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic r_busy;
    logic r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W-1:0] r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [DSR_W-1:0] r_dsr;
    logic [DVD_W-1:0] r_quot;
    logic [DSR_W:0] rem_sh;
    logic q_bit;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign q_bit = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(DVD_W);
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_rem <= q_bit ? DSR_W'(rem_sh - {1'b0, r_dsr}) : rem_sh[DSR_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quot <= {r_quot[DVD_W-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

/* design/grc_front.sv */
module grc_front (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input grc_pkg::t_in_item i_item,
    output logic o_stall,
    input logic i_clearing,
    input logic i_pop,
    output logic o_empty,
    output grc_pkg::t_task o_task
);
    import grc_pkg::*;

    t_task r_q [2];
    logic r_wp;
    logic r_rp;
    logic [1:0] r_cnt;
    logic keep;
    logic push;
    logic pop;

    // casts off the screen are taken and dropped here
    assign keep = (i_item.action == ACT_WRITE) || (32'(i_item.column) < SCREEN_W);
    assign o_stall = (r_cnt == 2'd2) || i_clearing;
    assign push = i_valid && !o_stall && keep;
    assign pop = i_pop && (r_cnt != 2'd0);
    assign o_empty = (r_cnt == 2'd0);
    assign o_task = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{is_cast: i_item.action == ACT_CAST, idx: i_item.cell_index,
                           val: i_item.cell_value, col: i_item.column};
        end
    end
endmodule

/* design/grc_back.sv */
module grc_back #(
    parameter int MAP_CELLS_MAX = grc_pkg::MAP_CELLS_MAX_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input grc_pkg::t_cfg i_cfg,
    input logic i_empty,
    input grc_pkg::t_task i_task,
    output logic o_pop,
    output logic o_clearing,
    output logic o_valid,
    output grc_pkg::t_out_item o_item,
    input logic i_stall
);
    import grc_pkg::*;

    localparam int AW = MAP_CELLS_MAX > 1 ? $clog2(MAP_CELLS_MAX) : 1;
    // column scale by reciprocal multiplication, exact for every 9-bit column
    localparam int N_SHIFT = 20;
    localparam logic [36:0] N_RECIP =
        37'(((64'd1 << (17 + N_SHIFT)) + 64'(SCREEN_W - 1)) / 64'(SCREEN_W));

    typedef enum logic [16:0] {
        S_CLEAR = 17'h00001,
        S_IDLE  = 17'h00002,
        S_NDIV  = 17'h00004,
        S_RAYM  = 17'h00008,
        S_RAYA  = 17'h00010,
        S_DXDIV = 17'h00020,
        S_DYDIV = 17'h00040,
        S_SDM   = 17'h00080,
        S_STEP  = 17'h00100,
        S_ADDR  = 17'h00200,
        S_READ  = 17'h00400,
        S_PERP  = 17'h00800,
        S_LHDIV = 17'h01000,
        S_WMUL  = 17'h02000,
        S_SDIV  = 17'h04000,
        S_TMUL  = 17'h08000,
        S_EMIT  = 17'h10000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0] r_clr;
    logic [8:0] r_col;
    logic signed [17:0] r_n;
    logic signed [35:0] r_pmx, r_pmy;
    logic signed [19:0] r_rx, r_ry;
    logic [DXY_W-1:0] r_dx, r_dy;
    logic [DIST_W-1:0] r_sdx, r_sdy;
    logic signed [7:0] r_mx, r_my;
    logic r_hside;
    logic [6:0] r_cnt;
    logic r_addr_ok;
    logic [3:0] r_hit;
    logic r_oob;
    logic [DIST_W-1:0] r_perp;
    logic [LH_W-1:0] r_lh;
    logic [31:0] r_wprod;
    logic [5:0] r_texx;
    logic [21:0] r_step;
    logic [LH_W+21:0] r_tprod;
    logic r_out_valid;
    t_out_item r_out;

    logic div_start, div_done;
    logic [DVD_W-1:0] div_dvd, div_q;
    logic [DSR_W-1:0] div_dsr;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [3:0] ram_wdata, ram_rdata;

    logic signed [19:0] rx_c, ry_c;
    logic [19:0] abs_rx_c, abs_ry;
    logic [11:0] idx12, addr_c;
    logic idx_ok, addr_ok_c, oob_c;
    logic signed [7:0] side_s, stx, sty;
    logic [6:0] limit;
    logic [16:0] fr_x, fr_y;
    logic signed [19:0] wsel;
    logic [15:0] frac;
    logic [23:0] txp;
    logic [7:0] tx8, txm;
    logic [LH_W-1:0] half, factor;
    logic [45:0] nprod;
    logic out_free;
    t_out_item res;

    grc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dvd),
        .i_divisor (div_dsr),
        .o_done    (div_done),
        .o_quot    (div_q)
    );

    grc_ram #(.WIDTH(4), .DEPTH(MAP_CELLS_MAX)) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign nprod = 46'(r_col) * 46'(N_RECIP);

    assign rx_c = {{2{i_cfg.dir_x[17]}}, i_cfg.dir_x} + r_pmx[35:16];
    assign ry_c = {{2{i_cfg.dir_y[17]}}, i_cfg.dir_y} + r_pmy[35:16];
    assign abs_rx_c = rx_c[19] ? 20'(-rx_c) : 20'(rx_c);
    assign abs_ry = r_ry[19] ? 20'(-r_ry) : 20'(r_ry);
    assign stx = (r_rx > 0) ? 8'sd1 : (r_rx < 0 ? -8'sd1 : 8'sd0);
    assign sty = (r_ry > 0) ? 8'sd1 : (r_ry < 0 ? -8'sd1 : 8'sd0);
    assign limit = {i_cfg.map_side, 1'b1};
    assign side_s = {2'b00, i_cfg.map_side};
    assign fr_x = r_rx[19] ? {1'b0, i_cfg.pos_x[15:0]} : 17'h10000 - {1'b0, i_cfg.pos_x[15:0]};
    assign fr_y = r_ry[19] ? {1'b0, i_cfg.pos_y[15:0]} : 17'h10000 - {1'b0, i_cfg.pos_y[15:0]};

    assign idx12 = {2'b00, i_task.idx};
    assign idx_ok = 32'(idx12) < MAP_CELLS_MAX;
    assign oob_c = (r_mx < 0) || (r_mx >= side_s) || (r_my < 0) || (r_my >= side_s);
    assign addr_c = 12'(12'(r_my[5:0]) * 12'(i_cfg.map_side)) + 12'(r_mx[5:0]);
    assign addr_ok_c = 32'(addr_c) < MAP_CELLS_MAX;

    // texture column from the low word of the wall hit coordinate
    assign wsel = r_hside ? r_rx : r_ry;
    assign frac = (r_hside ? i_cfg.pos_x[15:0] : i_cfg.pos_y[15:0]) + r_wprod[31:16];
    assign txp = 24'(frac) * 24'(TEX_SIZE);
    assign tx8 = txp[23:16];
    assign txm = ((!r_hside && r_rx > 0) || (r_hside && r_ry < 0)) ?
                 8'(TEX_SIZE - 1) - tx8 : tx8;

    assign half = r_lh >> 1;
    assign factor = (half > LH_W'(HALF_H)) ? half - LH_W'(HALF_H) : '0;

    always_comb begin
        res = '0;
        res.column_out = r_col;
        res.out_of_bounds = r_oob;
        if (!r_oob) begin
            res.texture_id = r_hit - 4'd1;
            res.hit_side = r_hside;
            res.perp_dist = (r_perp > DIST_W'(SAT24)) ? SAT24 : r_perp[23:0];
            res.wall_bottom = (half >= LH_W'(HALF_H)) ? 8'd0 : 8'(LH_W'(HALF_H) - half);
            res.wall_top = (half > LH_W'(SCREEN_H - 1 - HALF_H)) ? 8'(SCREEN_H - 1) :
                           8'(LH_W'(HALF_H) + half);
            res.tex_x = r_texx;
            res.tex_start = (r_tprod > (LH_W+22)'(SAT22)) ? SAT22 : r_tprod[21:0];
            res.tex_step = r_step;
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid = r_out_valid;
    assign o_item = r_out;

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = idx12[AW-1:0];
        ram_wdata = i_task.val;
        ram_raddr = addr_c[AW-1:0];
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = 4'd0;
        end else if (o_pop && !i_task.is_cast && idx_ok) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        div_start = 1'b0;
        div_dvd = DVD_W'(64'h1_0000_0000);
        div_dsr = DSR_W'(1);
        unique case (r_state)
            S_RAYA: begin
                div_start = 1'b1;
                div_dsr = (abs_rx_c == 20'd0) ? DSR_W'(1) : DSR_W'(abs_rx_c);
            end
            S_DXDIV: begin
                div_start = div_done;
                div_dsr = (abs_ry == 20'd0) ? DSR_W'(1) : DSR_W'(abs_ry);
            end
            S_PERP: begin
                div_start = 1'b1;
                div_dvd = DVD_W'(SCREEN_H) << 16;
                div_dsr = (r_perp == '0) ? DSR_W'(1) : DSR_W'(r_perp);
            end
            S_WMUL: begin
                div_start = 1'b1;
                div_dvd = DVD_W'(TEX_SIZE) << 16;
                div_dsr = (r_lh == '0) ? DSR_W'(1) : DSR_W'(r_lh);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (32'(r_clr) == MAP_CELLS_MAX - 1) n_state = S_IDLE;
            S_IDLE:  if (o_pop && i_task.is_cast) n_state = S_NDIV;
            S_NDIV:  n_state = S_RAYM;
            S_RAYM:  n_state = S_RAYA;
            S_RAYA:  n_state = S_DXDIV;
            S_DXDIV: if (div_done) n_state = S_DYDIV;
            S_DYDIV: if (div_done) n_state = S_SDM;
            S_SDM:   n_state = S_STEP;
            S_STEP:  n_state = (r_cnt == limit) ? S_EMIT : S_ADDR;
            S_ADDR:  n_state = oob_c ? S_EMIT : S_READ;
            S_READ:  n_state = (r_addr_ok && ram_rdata != 4'd0) ? S_PERP : S_STEP;
            S_PERP:  n_state = S_LHDIV;
            S_LHDIV: if (div_done) n_state = S_WMUL;
            S_WMUL:  n_state = S_SDIV;
            S_SDIV:  if (div_done) n_state = S_TMUL;
            S_TMUL:  n_state = S_EMIT;
            S_EMIT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_col <= i_task.col;
                r_oob <= 1'b0;
            end
            S_NDIV: r_n <= 18'(nprod[45:N_SHIFT]) - 18'h10000;
            S_RAYM: begin
                r_pmx <= i_cfg.plane_x * r_n;
                r_pmy <= i_cfg.plane_y * r_n;
            end
            S_RAYA: begin
                r_rx <= rx_c;
                r_ry <= ry_c;
                r_mx <= {3'b000, i_cfg.pos_x[20:16]};
                r_my <= {3'b000, i_cfg.pos_y[20:16]};
            end
            S_DXDIV: if (div_done) r_dx <= (r_rx == 0) ? DIST_INF : DXY_W'(div_q);
            S_DYDIV: if (div_done) r_dy <= (r_ry == 0) ? DIST_INF : DXY_W'(div_q);
            S_SDM: begin
                r_sdx <= DIST_W'(51'(51'(fr_x) * 51'(r_dx)) >> 16);
                r_sdy <= DIST_W'(51'(51'(fr_y) * 51'(r_dy)) >> 16);
                r_cnt <= 7'd0;
            end
            S_STEP: begin
                if (r_cnt == limit) begin
                    r_oob <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_sdx < r_sdy) begin
                        r_sdx <= r_sdx + DIST_W'(r_dx);
                        r_mx <= r_mx + stx;
                        r_hside <= 1'b0;
                    end else begin
                        r_sdy <= r_sdy + DIST_W'(r_dy);
                        r_my <= r_my + sty;
                        r_hside <= 1'b1;
                    end
                end
            end
            S_ADDR: begin
                r_addr_ok <= addr_ok_c;
                if (oob_c) r_oob <= 1'b1;
            end
            S_READ: begin
                r_hit <= ram_rdata;
                r_perp <= r_hside ? r_sdy - DIST_W'(r_dy) : r_sdx - DIST_W'(r_dx);
            end
            S_LHDIV: if (div_done) r_lh <= div_q[LH_W-1:0];
            S_WMUL: r_wprod <= 32'(r_perp[31:0] * {{12{wsel[19]}}, wsel});
            S_SDIV: begin
                r_texx <= txm[5:0];
                if (div_done) begin
                    r_step <= (r_lh == '0 || div_q > DVD_W'(SAT22)) ? SAT22 : div_q[21:0];
                end
            end
            S_TMUL: r_tprod <= (LH_W+22)'(factor) * (LH_W+22)'(r_step);
            S_EMIT: if (out_free) r_out <= res;
            default: begin
            end
        endcase
    end
endmodule

/* design/grid_raycast_column_top.sv */
// Column ray caster over a square map of 4-bit cells (0 = empty). A write
// transaction stores one cell and returns nothing; a cast transaction for an
// on-screen column returns one result, casts beyond the screen width return
// nothing. After reset the map is cleared one cell per cycle, and input is
// stalled while it clears; configuration writes are taken at any time but should
// only be made while the block is idle. A cast makes four divisions in the
// shared bit-serial divider (two cell deltas, line height, texture step) plus
// multiply steps, and a walk of up to 2 * map_side + 1 grid steps, each going
// through the step, address and read states. A two-entry queue and an output
// register let input and output keep moving while a cast is in progress.
module grid_raycast_column_top #(
    parameter int MAP_CELLS_MAX = grc_pkg::MAP_CELLS_MAX_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input grc_pkg::t_in_item i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output grc_pkg::t_out_item o_out_data,
    input logic i_out_stall,
    input logic i_cfg_valid,
    output logic o_cfg_ready,
    input logic [2:0] i_cfg_index,
    input logic [20:0] i_cfg_data
);
    import grc_pkg::*;

    t_cfg r_cfg;
    t_task q_task;
    logic q_empty;
    logic q_pop;
    logic clearing;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x <= 21'd98304;
            r_cfg.pos_y <= 21'd98304;
            r_cfg.dir_x <= -18'sd65536;
            r_cfg.dir_y <= 18'sd0;
            r_cfg.plane_x <= 18'sd0;
            r_cfg.plane_y <= 18'sd43254;
            r_cfg.map_side <= 6'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_POS_X:    r_cfg.pos_x <= i_cfg_data;
                CFG_POS_Y:    r_cfg.pos_y <= i_cfg_data;
                CFG_DIR_X:    r_cfg.dir_x <= i_cfg_data[17:0];
                CFG_DIR_Y:    r_cfg.dir_y <= i_cfg_data[17:0];
                CFG_PLANE_X:  r_cfg.plane_x <= i_cfg_data[17:0];
                CFG_PLANE_Y:  r_cfg.plane_y <= i_cfg_data[17:0];
                CFG_MAP_SIDE: r_cfg.map_side <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    grc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (i_in_data),
        .o_stall   (o_in_stall),
        .i_clearing(clearing),
        .i_pop     (q_pop),
        .o_empty   (q_empty),
        .o_task    (q_task)
    );

    grc_back #(.MAP_CELLS_MAX(MAP_CELLS_MAX)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_empty   (q_empty),
        .i_task    (q_task),
        .o_pop     (q_pop),
        .o_clearing(clearing),
        .o_valid   (o_out_valid),
        .o_item    (o_out_data),
        .i_stall   (i_out_stall)
    );
endmodule
